[hw/rtl/mcfp_pkg.sv]
// Package for the motor command frame parser: character codes, frame limits,
// payload and status structs, and the decimal digit helper.
// No dependencies.
`timescale 1ns / 1ps

package mcfp_pkg;

	// Frame delimiters and command letters (ASCII)
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_QUERY  = 8'h3F;
	localparam logic [7:0] CH_F      = 8'h46;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;
	localparam logic [7:0] CH_R      = 8'h52;

	// Beat operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_STOP = 1'b1;

	// Frame geometry
	localparam int FRAME_LIMIT = 20;
	localparam int FRAME_DEPTH = 7;
	localparam int IDX_W       = $clog2(FRAME_DEPTH);
	localparam int CNT_W       = 5;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef logic [FRAME_DEPTH-1:0][7:0] frame_t;
	typedef logic [CNT_W-1:0]            count_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  step_mode;
		logic [9:0]  max_current;
		logic [9:0]  hold_current;
		logic [3:0]  direction;
		logic [13:0] step_total;
		logic [6:0]  step_wait;
		logic [3:0]  run_flag;
	} settings_t;

	typedef struct packed {
		logic [7:0]  step_mode;
		logic [9:0]  max_current;
		logic [9:0]  hold_current;
		logic [3:0]  direction;
		logic [13:0] step_total;
		logic [6:0]  step_wait;
		logic [3:0]  run_flag;
		logic        report_request;
		logic        frame_done;
	} sts_t;

	typedef struct packed {
		logic close;
		logic done;
		logic report;
	} dec_status_t;

	localparam settings_t SET_RESET = '{
		step_mode:    CH_F,
		max_current:  10'd100,
		hold_current: 10'd50,
		direction:    4'd0,
		step_total:   14'd200,
		step_wait:    7'd2,
		run_flag:     4'd0
	};

	// Low nibble of an ASCII digit, clamped to 9
	function automatic logic [3:0] digit_value(input logic [7:0] b);
		logic [3:0] d;
		d = b[3:0];
		return (d > 4'd9) ? 4'd9 : d;
	endfunction

endpackage

[hw/rtl/mcfp_decode.sv]
// Single-pass next-state logic for one beat: frame append, frame close and
// command decode into the motor settings. Depends on mcfp_pkg.
`timescale 1ns / 1ps

module mcfp_decode (
	input  mcfp_pkg::cmd_t        cmd,
	input  mcfp_pkg::settings_t   set_cur,
	input  mcfp_pkg::frame_t      frame_cur,
	input  mcfp_pkg::count_t      cnt_cur,
	output mcfp_pkg::settings_t   set_nxt,
	output mcfp_pkg::frame_t      frame_nxt,
	output mcfp_pkg::count_t      cnt_nxt,
	output mcfp_pkg::dec_status_t status
);
	import mcfp_pkg::*;

	logic       is_byte;
	logic       is_at;
	logic       is_end;
	count_t     wr_pos;
	count_t     cnt_inc;
	logic       close;
	logic       done;
	logic [7:0] cmd_ch;
	logic [7:0] sub_ch;
	logic [3:0] d3, d4, d5, d6;
	logic [6:0] val2;
	logic [9:0] val3;
	logic [13:0] val4;

	// Classify the beat
	assign is_byte = (cmd.op == OP_BYTE);
	assign is_at   = is_byte && (cmd.rx_byte == CH_AT);
	assign is_end  = is_byte && (cmd.rx_byte == CH_DOLLAR);

	// An '@' restarts the frame at position 0
	assign wr_pos  = is_at ? '0 : cnt_cur;
	assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

	// Close on '$' while the count, '$' included, stays below the limit
	assign close = is_end && (({1'b0, cnt_cur} + 6'd1) < 6'(FRAME_LIMIT));
	assign done  = close && (cnt_cur != '0) && (frame_cur[0] == CH_AT);

	assign cmd_ch = frame_cur[1];
	assign sub_ch = frame_cur[2];

	// Constant-weight decimal sums over argument positions 3 to 6
	assign d3 = digit_value(frame_cur[3]);
	assign d4 = digit_value(frame_cur[4]);
	assign d5 = digit_value(frame_cur[5]);
	assign d6 = digit_value(frame_cur[6]);

	assign val2 = ({3'b0, d3} * 7'd10) + {3'b0, d4};
	assign val3 = ({6'b0, d3} * 10'd100) + ({6'b0, d4} * 10'd10) + {6'b0, d5};
	assign val4 = ({10'b0, d3} * 14'd1000) + ({10'b0, d4} * 14'd100)
		+ ({10'b0, d5} * 14'd10) + {10'b0, d6};

	// Append the byte and advance the count; '@' restarts it and a close clears it
	always_comb begin
		frame_nxt = frame_cur;
		if (is_byte && (wr_pos < CNT_W'(FRAME_DEPTH))) begin
			frame_nxt[wr_pos[IDX_W-1:0]] = cmd.rx_byte;
		end
		if (!is_byte) begin
			cnt_nxt = cnt_cur;
		end else if (is_at) begin
			cnt_nxt = CNT_W'(1);
		end else if (close) begin
			cnt_nxt = '0;
		end else begin
			cnt_nxt = cnt_inc;
		end
	end

	// Apply the decoded command, or a stop request, to the settings
	always_comb begin
		set_nxt = set_cur;
		if (cmd.op == OP_STOP) begin
			set_nxt.run_flag = '0;
		end else if (done && (cnt_cur >= CNT_W'(3))) begin
			case (cmd_ch)
				CH_M: begin
					if ((sub_ch == CH_F) || (sub_ch == CH_M) || (sub_ch == CH_H)) begin
						set_nxt.step_mode = sub_ch;
					end
				end
				CH_A: begin
					if (cnt_cur >= CNT_W'(6)) begin
						if (sub_ch == CH_M) begin
							set_nxt.max_current = val3;
						end else if (sub_ch == CH_H) begin
							set_nxt.hold_current = val3;
						end
					end
				end
				CH_C: begin
					if ((sub_ch == CH_D) && (cnt_cur >= CNT_W'(4))) begin
						set_nxt.direction = frame_cur[3][3:0];
					end else if ((sub_ch == CH_S) && (cnt_cur >= CNT_W'(7))) begin
						set_nxt.step_total = val4;
					end else if ((sub_ch == CH_W) && (cnt_cur >= CNT_W'(5))) begin
						set_nxt.step_wait = val2;
					end else if ((sub_ch == CH_R) && (cnt_cur >= CNT_W'(4))) begin
						set_nxt.run_flag = frame_cur[3][3:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign status.close  = close;
	assign status.done   = done;
	assign status.report = done && (cnt_cur >= CNT_W'(2)) && (cmd_ch == CH_QUERY);

endmodule

[hw/rtl/motor_command_frame_parser_core.sv]
// Motor command frame parser: beat input register, frame and settings
// state, and the status output register. Depends on mcfp_pkg, mcfp_decode.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd): one beat per received serial
//   byte (op = OP_BYTE) or a stop request (op = OP_STOP) that clears run.
//   Frames look like '@', command letter, sub-letter, ASCII arguments, '$'.
//   sts channel (sts_valid/sts_ready/sts): exactly one status beat per cmd
//   beat, carrying all motor settings after that beat plus frame_done and
//   report_request flags for the beat that closed a frame.
//   A cmd beat passes through the input register, then the status register.
//   Throughput: one beat per cycle while sts_ready stays high; the decode is a
//   single combinational pass between the input register and the status register.
//   Stall: while sts_ready is low the status register holds; one more cmd
//   beat is taken into the input register if it is empty, then cmd_ready drops.
//   Reset: settings return to mode F, max current 100, hold current 50,
//   direction 0, 200 steps, wait 2, run 0; the frame empties; both
//   registers are emptied. No clearing pass is needed.
`timescale 1ns / 1ps

module motor_command_frame_parser_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  mcfp_pkg::cmd_t   cmd,
	output logic             sts_valid,
	input  logic             sts_ready,
	output mcfp_pkg::sts_t   sts
);
	import mcfp_pkg::*;

	cmd_t        cmd_s1;
	logic        cmd_vld_s1;
	settings_t   set_q;
	frame_t      frame_q;
	count_t      cnt_q;
	sts_t        sts_q;
	logic        sts_vld_q;
	logic        proc;
	settings_t   set_nxt;
	frame_t      frame_nxt;
	count_t      cnt_nxt;
	dec_status_t dec;

	// Process the held beat when the status register is free or draining
	assign proc      = cmd_vld_s1 && (!sts_vld_q || sts_ready);
	assign cmd_ready = !cmd_vld_s1 || proc;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_s1 <= 1'b0;
		end else if (cmd_ready) begin
			cmd_vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	mcfp_decode u_decode (
		.cmd       (cmd_s1),
		.set_cur   (set_q),
		.frame_cur (frame_q),
		.cnt_cur   (cnt_q),
		.set_nxt   (set_nxt),
		.frame_nxt (frame_nxt),
		.cnt_nxt   (cnt_nxt),
		.status    (dec)
	);

	// Settings and frame count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q <= SET_RESET;
			cnt_q <= '0;
		end else if (proc) begin
			set_q <= set_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	// Frame bytes: undefined until written
	always_ff @(posedge clk) begin
		if (proc) begin
			frame_q <= frame_nxt;
		end
	end

	// Status output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sts_vld_q <= 1'b0;
		end else if (proc) begin
			sts_vld_q <= 1'b1;
		end else if (sts_ready) begin
			sts_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			sts_q <= '{
				step_mode:      set_nxt.step_mode,
				max_current:    set_nxt.max_current,
				hold_current:   set_nxt.hold_current,
				direction:      set_nxt.direction,
				step_total:     set_nxt.step_total,
				step_wait:      set_nxt.step_wait,
				run_flag:       set_nxt.run_flag,
				report_request: dec.report,
				frame_done:     dec.done
			};
		end
	end

	assign sts_valid = sts_vld_q;
	assign sts       = sts_q;

`ifndef ASSERT_OFF
	a_report_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts_vld_q && sts_q.report_request |-> sts_q.frame_done)
		else $error("report_request without frame_done");

	a_stop_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (cmd_s1.op == OP_STOP) |=> (sts_q.run_flag == '0) && !sts_q.frame_done)
		else $error("stop beat did not clear run flag");

	a_close_empties: assert property (@(posedge clk) disable iff (!arst_n)
		proc && dec.close |=> (cnt_q == '0))
		else $error("closed frame left a nonzero count");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_vld_s1 && !proc |=> cmd_vld_s1 && $stable(cmd_s1))
		else $error("input register lost an unprocessed beat");

	a_settings_range: assert property (@(posedge clk) disable iff (!arst_n)
		sts_vld_q |-> (sts_q.max_current <= 10'd999) && (sts_q.hold_current <= 10'd999)
			&& (sts_q.step_total <= 14'd9999) && (sts_q.step_wait <= 7'd99))
		else $error("decimal setting out of range");
`endif

endmodule

[test/motor_command_frame_parser_core_tb.sv]
// Testbench for motor_command_frame_parser_core: directed frames, then random
// frame traffic with idling on both channels, each status beat checked against a
// local settings predictor. Depends on mcfp_pkg and the core RTL.
`timescale 1ns / 1ps

module motor_command_frame_parser_core_tb;
	import mcfp_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int MAX_PRINTS   = 40;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ALL1  = 8'hFF;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic sts_ready = 1'b0;
	cmd_t cmd       = '0;
	logic cmd_ready;
	logic sts_valid;
	sts_t sts;

	motor_command_frame_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.sts_valid (sts_valid),
		.sts_ready (sts_ready),
		.sts       (sts)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predicted motor settings and frame buffer
	logic [7:0]  mode_q;
	logic [9:0]  max_cur_q;
	logic [9:0]  hold_cur_q;
	logic [3:0]  dir_q;
	logic [13:0] steps_q;
	logic [6:0]  wait_q;
	logic [3:0]  run_q;
	logic [7:0]  frame_q [FRAME_DEPTH];
	logic [4:0]  count_q;

	sts_t pending_status [$];

	int error_count    = 0;
	int beats_sent     = 0;
	int stops_sent     = 0;
	int beats_checked  = 0;
	int frames_decoded = 0;
	int queries_seen   = 0;
	int cycle_count    = 0;
	int stall_left     = 0;
	bit quiet          = 1'b0;

	// Gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [3:0] clamp_digit(input logic [7:0] b);
		return (b[3:0] > 4'd9) ? 4'd9 : b[3:0];
	endfunction

	function automatic int frame_number(input int first, input int ndig);
		int v;
		v = 0;
		for (int i = 0; i < ndig; i++)
			v = v * 10 + clamp_digit(frame_q[first + i]);
		return v;
	endfunction

	task automatic reset_settings();
		mode_q     = CH_F;
		max_cur_q  = 10'd100;
		hold_cur_q = 10'd50;
		dir_q      = 4'd0;
		steps_q    = 14'd200;
		wait_q     = 7'd2;
		run_q      = 4'd0;
		count_q    = '0;
		for (int i = 0; i < FRAME_DEPTH; i++)
			frame_q[i] = '0;
	endtask

	// Append one byte; positions past the buffer are counted only
	task automatic store_byte(input logic [7:0] b);
		if (count_q < FRAME_DEPTH)
			frame_q[count_q] = b;
		if (count_q != 5'd31)
			count_q = count_q + 5'd1;
	endtask

	// Apply a closed frame of n bytes before '$' to the settings
	task automatic decode_frame(input int n, output logic report);
		logic [7:0] letter;
		logic [7:0] sub;
		letter = (n >= 2) ? frame_q[1] : CH_DOLLAR;
		sub    = (n >= 3) ? frame_q[2] : 8'h00;
		report = 1'b0;
		if (letter == CH_QUERY) begin
			report = 1'b1;
		end else if (n >= 3) begin
			if (letter == CH_M) begin
				if (sub == CH_F || sub == CH_M || sub == CH_H)
					mode_q = sub;
			end else if (letter == CH_A) begin
				if (n >= 6 && sub == CH_M)
					max_cur_q = 10'(frame_number(3, 3));
				else if (n >= 6 && sub == CH_H)
					hold_cur_q = 10'(frame_number(3, 3));
			end else if (letter == CH_C) begin
				if (sub == CH_D && n >= 4)
					dir_q = frame_q[3][3:0];
				else if (sub == CH_S && n >= 7)
					steps_q = 14'(frame_number(3, 4));
				else if (sub == CH_W && n >= 5)
					wait_q = 7'(frame_number(3, 2));
				else if (sub == CH_R && n >= 4)
					run_q = frame_q[3][3:0];
			end
		end
	endtask

	// Advance the predicted state by one beat and form its status
	task automatic apply_beat(input logic op, input logic [7:0] b, output sts_t s);
		int n;
		logic done;
		logic report;
		done   = 1'b0;
		report = 1'b0;
		if (op == OP_STOP) begin
			run_q = 4'd0;
		end else if (b == CH_AT) begin
			count_q = '0;
			store_byte(b);
		end else if (b == CH_DOLLAR) begin
			n = count_q;
			store_byte(b);
			if (n + 1 < FRAME_LIMIT) begin
				if (frame_q[0] == CH_AT && n >= 1) begin
					done = 1'b1;
					decode_frame(n, report);
				end
				count_q = '0;
			end
		end else begin
			store_byte(b);
		end
		s.step_mode      = mode_q;
		s.max_current    = max_cur_q;
		s.hold_current   = hold_cur_q;
		s.direction      = dir_q;
		s.step_total     = steps_q;
		s.step_wait      = wait_q;
		s.run_flag       = run_q;
		s.report_request = report;
		s.frame_done     = done;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h (status beat %0d)",
				what, got, want, beats_checked);
	endtask

	task automatic check_status(input sts_t got, input sts_t want);
		if (got.step_mode !== want.step_mode)
			report_mismatch("step_mode", got.step_mode, want.step_mode);
		if (got.max_current !== want.max_current)
			report_mismatch("max_current", got.max_current, want.max_current);
		if (got.hold_current !== want.hold_current)
			report_mismatch("hold_current", got.hold_current, want.hold_current);
		if (got.direction !== want.direction)
			report_mismatch("direction", got.direction, want.direction);
		if (got.step_total !== want.step_total)
			report_mismatch("step_total", got.step_total, want.step_total);
		if (got.step_wait !== want.step_wait)
			report_mismatch("step_wait", got.step_wait, want.step_wait);
		if (got.run_flag !== want.run_flag)
			report_mismatch("run_flag", got.run_flag, want.run_flag);
		if (got.report_request !== want.report_request)
			report_mismatch("report_request", got.report_request, want.report_request);
		if (got.frame_done !== want.frame_done)
			report_mismatch("frame_done", got.frame_done, want.frame_done);
	endtask

	// Send one beat; hold valid and payload until accepted, then predict
	task automatic send_beat(input logic op, input logic [7:0] b);
		int gap;
		sts_t want;
		gap = pick_gap();
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= '{op: op, rx_byte: b};
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		apply_beat(op, b, want);
		pending_status.push_back(want);
		beats_sent++;
		if (op == OP_STOP)
			stops_sent++;
		if (want.frame_done)
			frames_decoded++;
		if (want.report_request)
			queries_seen++;
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_beat(OP_BYTE, text[i]);
	endtask

	// Check status beats and stall the status channel
	always @(posedge clk) begin
		if (arst_n) begin
			if (sts_valid && sts_ready) begin
				if (pending_status.size() == 0)
					report_mismatch("status beat with nothing pending", 32'(sts), '0);
				else
					check_status(sts, pending_status.pop_front());
				beats_checked++;
			end
			if (stall_left != 0) begin
				sts_ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				sts_ready <= (stall_left == 0);
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d status beats pending",
				cycle_count, pending_status.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Random byte that neither starts nor closes a frame
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = $urandom_range(0, 255);
		if (b == CH_AT || b == CH_DOLLAR)
			b = b ^ 8'h80;
		return b;
	endfunction

	function automatic logic [7:0] digit_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return CH_ZERO + 8'($urandom_range(0, 9));
		if (r == 8)
			return CH_ZERO | 8'($urandom_range(0, 15));
		return plain_byte();
	endfunction

	// Well-formed command frame with random content, sometimes short of arguments or with extra ones
	task automatic send_command_frame();
		logic [7:0] fb [$];
		logic [7:0] sub;
		int need;
		int sel;
		sel  = $urandom_range(0, 11);
		need = 0;
		fb.push_back(CH_AT);
		case (sel)
			0, 1: begin
				fb.push_back(CH_M);
				case ($urandom_range(0, 3))
					0: sub = CH_F;
					1: sub = CH_M;
					2: sub = CH_H;
					default: sub = plain_byte();
				endcase
				fb.push_back(sub);
			end
			2: begin
				fb.push_back(CH_A);
				fb.push_back(CH_M);
				need = 3;
			end
			3: begin
				fb.push_back(CH_A);
				fb.push_back(CH_H);
				need = 3;
			end
			4: begin
				fb.push_back(CH_C);
				fb.push_back(CH_D);
				need = -1;
			end
			5: begin
				fb.push_back(CH_C);
				fb.push_back(CH_S);
				need = 4;
			end
			6: begin
				fb.push_back(CH_C);
				fb.push_back(CH_W);
				need = 2;
			end
			7, 8: begin
				fb.push_back(CH_C);
				fb.push_back(CH_R);
				need = -1;
			end
			9: begin
				fb.push_back(CH_QUERY);
				if ($urandom_range(0, 1))
					fb.push_back(plain_byte());
			end
			10: begin
				fb.push_back(CH_C);
				fb.push_back(plain_byte());
				need = 2;
			end
			default: begin
				fb.push_back(plain_byte());
				fb.push_back(plain_byte());
				need = 1;
			end
		endcase
		// Nibble arguments take any byte; decimal ones mostly take digits
		if (need < 0) begin
			if ($urandom_range(0, 9) != 0)
				fb.push_back(plain_byte());
		end else begin
			if (need > 0 && $urandom_range(0, 6) == 0)
				need = $urandom_range(0, need - 1);
			else if ($urandom_range(0, 9) == 0)
				need = need + $urandom_range(1, 3);
			repeat (need) fb.push_back(digit_byte());
		end
		if ($urandom_range(0, 15) == 0)
			fb = fb[0:$urandom_range(0, fb.size() - 1)];
		fb.push_back(CH_DOLLAR);
		foreach (fb[i]) begin
			if ($urandom_range(0, 39) == 0)
				send_beat(OP_STOP, 8'($urandom_range(0, 255)));
			send_beat(OP_BYTE, fb[i]);
		end
	endtask

	// Over-length frame around the limit, then more bytes past the close
	task automatic send_long_frame();
		int body;
		body = $urandom_range(14, 36);
		send_beat(OP_BYTE, CH_AT);
		repeat (body) send_beat(OP_BYTE, digit_byte());
		send_beat(OP_BYTE, CH_DOLLAR);
		repeat ($urandom_range(0, 4)) send_beat(OP_BYTE, plain_byte());
		if ($urandom_range(0, 1))
			send_beat(OP_BYTE, CH_DOLLAR);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 4) == 0)
				send_beat(OP_STOP, 8'($urandom_range(0, 255)));
			else
				send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_mode_letter();
		send_text("@MH$");
	endtask

	// Middle digit is a colon, which clamps to nine
	task automatic test_clamped_current();
		send_beat(OP_BYTE, CH_AT);
		send_beat(OP_BYTE, CH_A);
		send_beat(OP_BYTE, CH_M);
		send_beat(OP_BYTE, CH_ZERO + 8'd9);
		send_beat(OP_BYTE, CH_COLON);
		send_beat(OP_BYTE, CH_ZERO);
		send_beat(OP_BYTE, CH_DOLLAR);
	endtask

	task automatic test_query();
		send_text("@?$");
	endtask

	task automatic test_run_setting();
		send_text("@CR");
		send_beat(OP_BYTE, CH_SEVEN);
		send_beat(OP_BYTE, CH_DOLLAR);
	endtask

	task automatic test_stop_request();
		send_beat(OP_STOP, CH_ALL1);
	endtask

	task automatic test_missing_start();
		send_beat(OP_BYTE, CH_NUL);
		send_beat(OP_BYTE, CH_DOLLAR);
	endtask

	task automatic test_short_arguments();
		send_text("@C$");
	endtask

	task automatic test_random_traffic();
		int r;
		while (beats_sent < RANDOM_ITEMS + 25) begin
			quiet = ((beats_sent / 150) % 4 == 2);
			r = $urandom_range(0, 99);
			if (r < 75)
				send_command_frame();
			else if (r < 87)
				send_long_frame();
			else
				send_noise();
		end
		quiet = 1'b0;
	endtask

	initial begin
		reset_settings();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_mode_letter();
		test_clamped_current();
		test_query();
		test_run_setting();
		test_stop_request();
		test_missing_start();
		test_short_arguments();
		test_random_traffic();

		// Drain, then allow for the register stage
		cmd_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("Sent %0d beats (%0d stop requests); %0d frames decoded, %0d queries.",
			beats_sent, stops_sent, frames_decoded, queries_seen);
		$display("Compared %0d status beats in %0d cycles.", beats_checked, cycle_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/mcfp_pkg.sv
hw/rtl/mcfp_decode.sv
hw/rtl/motor_command_frame_parser_core.sv
test/motor_command_frame_parser_core_tb.sv
